// ===== rtl/maf_pkg.sv =====
package maf_pkg;

  localparam int unsigned MaxWindow = 255;
  localparam int unsigned SampleW   = 16;
  localparam int unsigned WinW      = 8;
  localparam int unsigned TotalW    = 24;
  localparam int unsigned RingAddrW = $clog2(MaxWindow);

  // restoring divider: one quotient bit per cycle over the whole dividend
  localparam int unsigned DivSteps  = TotalW;
  localparam int unsigned DivCntW   = $clog2(DivSteps + 1);

  // job queue between front and back
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic [WinW-1:0] WindowReset = WinW'(16);

  typedef struct packed {
    logic [TotalW-1:0] dividend;
    logic [WinW-1:0]   divisor;
  } job_t;

endpackage

// ===== rtl/maf_front.sv =====
module maf_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [maf_pkg::SampleW-1:0]   sample_i,
  input  logic                          sample_valid_i,
  output logic                          sample_stall_o,
  input  logic                          cfg_we_i,
  input  logic [maf_pkg::WinW-1:0]      cfg_window_length_i,
  input  logic                          q_full_i,
  output logic                          push_o,
  output maf_pkg::job_t                 job_o
);

  localparam logic SIdle   = 1'b0;
  localparam logic SUpdate = 1'b1;

  logic                             state_q, state_d;
  logic [maf_pkg::SampleW-1:0]      sample_q;
  logic [maf_pkg::RingAddrW-1:0]    slot_q;
  logic                             full_q;
  logic [maf_pkg::SampleW-1:0]      rd_q;
  logic [maf_pkg::WinW-1:0]         win_q;
  logic [maf_pkg::RingAddrW-1:0]    wpos_q, wpos_d;
  logic [maf_pkg::WinW-1:0]         fill_q, fill_d;
  logic [maf_pkg::TotalW-1:0]       total_q, total_d;

  logic [maf_pkg::SampleW-1:0]      ring [maf_pkg::MaxWindow];

  logic [maf_pkg::WinW-1:0]         w_eff;
  logic [maf_pkg::RingAddrW-1:0]    slot_sel;
  logic [maf_pkg::RingAddrW-1:0]    slot_next;
  logic                             accept;
  logic                             commit;

  // zero acts as a window of one; anything beyond the ring depth is clamped
  always_comb begin
    if (win_q == '0) begin
      w_eff = maf_pkg::WinW'(1);
    end else if (win_q > maf_pkg::WinW'(maf_pkg::MaxWindow)) begin
      w_eff = maf_pkg::WinW'(maf_pkg::MaxWindow);
    end else begin
      w_eff = win_q;
    end
  end

  assign accept   = (state_q == SIdle) && sample_valid_i;
  assign commit   = (state_q == SUpdate) && !q_full_i;
  assign slot_sel = (maf_pkg::WinW'(wpos_q) >= w_eff) ? '0 : wpos_q;

  always_comb begin
    slot_next = slot_q + maf_pkg::RingAddrW'(1);
    if (maf_pkg::WinW'(slot_next) >= w_eff) begin
      slot_next = '0;
    end
    total_d = total_q + maf_pkg::TotalW'(sample_q);
    fill_d  = fill_q + maf_pkg::WinW'(1);
    if (full_q) begin
      total_d = total_d - maf_pkg::TotalW'(rd_q);
      fill_d  = w_eff;
    end
    wpos_d = slot_next;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SIdle:   if (accept) state_d = SUpdate;
      SUpdate: if (commit) state_d = SIdle;
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      win_q   <= maf_pkg::WindowReset;
      wpos_q  <= '0;
      fill_q  <= '0;
      total_q <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        win_q   <= cfg_window_length_i;
        wpos_q  <= '0;
        fill_q  <= '0;
        total_q <= '0;
      end else if (commit) begin
        wpos_q  <= wpos_d;
        fill_q  <= fill_d;
        total_q <= total_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= sample_i;
      slot_q   <= slot_sel;
      full_q   <= fill_q >= w_eff;
    end
  end

  // ring store: registered read on accept, write on commit
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q <= ring[slot_sel];
    end
    if (commit) begin
      ring[slot_q] <= sample_q;
    end
  end

  assign sample_stall_o = (state_q != SIdle);
  assign push_o         = commit;
  assign job_o.dividend = total_d;
  assign job_o.divisor  = fill_d;

endmodule

// ===== rtl/maf_queue.sv =====
module maf_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  maf_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output maf_pkg::job_t job_o
);

  maf_pkg::job_t                   entry_q [maf_pkg::QueueDepth];
  logic [maf_pkg::QueuePtrW-1:0]   wr_q, rd_q;
  logic [maf_pkg::QueueCntW-1:0]   cnt_q;
  logic                            do_push, do_pop;

  assign full_o  = (cnt_q == maf_pkg::QueueCntW'(maf_pkg::QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = entry_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == maf_pkg::QueuePtrW'(maf_pkg::QueueDepth - 1)) ?
                '0 : wr_q + maf_pkg::QueuePtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == maf_pkg::QueuePtrW'(maf_pkg::QueueDepth - 1)) ?
                '0 : rd_q + maf_pkg::QueuePtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + maf_pkg::QueueCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - maf_pkg::QueueCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_q] <= job_i;
    end
  end

endmodule

// ===== rtl/maf_div.sv =====
module maf_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        q_empty_i,
  input  maf_pkg::job_t               job_i,
  output logic                        pop_o,
  output logic [maf_pkg::SampleW-1:0] average_o,
  output logic                        average_valid_o,
  input  logic                        average_stall_i
);

  logic                            busy_q, done_q, out_valid_q;
  logic [maf_pkg::DivCntW-1:0]     cnt_q;
  logic [maf_pkg::TotalW-1:0]      quo_q;
  logic [maf_pkg::WinW-1:0]        rem_q;
  logic [maf_pkg::WinW-1:0]        div_q;
  logic [maf_pkg::SampleW-1:0]     out_q;

  logic [maf_pkg::WinW:0]          trial;
  logic                            ge;
  logic [maf_pkg::WinW-1:0]        rem_d;
  logic                            slot_free;
  logic                            load_out;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem_q, quo_q[maf_pkg::TotalW-1]};
  assign ge    = trial >= {1'b0, div_q};
  always_comb begin
    rem_d = trial[maf_pkg::WinW-1:0];
    if (ge) begin
      rem_d = maf_pkg::WinW'(trial - {1'b0, div_q});
    end
  end

  assign pop_o     = !busy_q && !done_q && !q_empty_i;
  assign slot_free = !out_valid_q || !average_stall_i;
  assign load_out  = done_q && slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      out_valid_q <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (pop_o) begin
        busy_q <= 1'b1;
        cnt_q  <= maf_pkg::DivCntW'(maf_pkg::DivSteps);
      end else if (busy_q) begin
        cnt_q <= cnt_q - maf_pkg::DivCntW'(1);
        if (cnt_q == maf_pkg::DivCntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end else if (load_out) begin
        done_q <= 1'b0;
      end
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!average_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      quo_q <= job_i.dividend;
      div_q <= job_i.divisor;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[maf_pkg::TotalW-2:0], ge};
      rem_q <= rem_d;
    end
    if (load_out) begin
      out_q <= quo_q[maf_pkg::SampleW-1:0];
    end
  end

  assign average_o       = out_q;
  assign average_valid_o = out_valid_q;

endmodule

// ===== rtl/moving_average_filter_top.sv =====
// Channel   | Direction | Handshake                         | Payload
// sample    | in        | sample_valid_i / sample_stall_o   | sample_i[15:0]
// average   | out       | average_valid_o / average_stall_i | average_o[15:0]
// config    | in        | cfg_we_i (no wait)                | cfg_window_length_i[7:0]
//
// Front: a sample is a ring read, then an update and job push that waits while the
// queue is full. Back: restoring divide, one quotient bit a cycle, then output load; the
// divider takes no new job until that load, which sets the sample rate. The two-deep job
// queue lets the front take samples while the divider is busy or a finished average
// waits under stall. Reset (async, active low) empties the filter and sets the window
// to 16; no ring clearing pass, as a slot is used only once written.
module moving_average_filter_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [maf_pkg::SampleW-1:0] sample_i,
  input  logic                        sample_valid_i,
  output logic                        sample_stall_o,
  output logic [maf_pkg::SampleW-1:0] average_o,
  output logic                        average_valid_o,
  input  logic                        average_stall_i,
  input  logic                        cfg_we_i,
  input  logic [maf_pkg::WinW-1:0]    cfg_window_length_i
);

  // front -> queue
  logic          push;
  logic          q_full;
  maf_pkg::job_t push_job;

  // queue -> divider
  logic          pop;
  logic          q_empty;
  maf_pkg::job_t pop_job;

  // Front: window bookkeeping, ring store, running total.
  maf_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .sample_i            (sample_i),
    .sample_valid_i      (sample_valid_i),
    .sample_stall_o      (sample_stall_o),
    .cfg_we_i            (cfg_we_i),
    .cfg_window_length_i (cfg_window_length_i),
    .q_full_i            (q_full),
    .push_o              (push),
    .job_o               (push_job)
  );

  // Jobs carry total and sample count, so the back needs no window state.
  maf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .job_o   (pop_job)
  );

  // Back: serial divider and output register.
  maf_div u_div (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_empty_i       (q_empty),
    .job_i           (pop_job),
    .pop_o           (pop),
    .average_o       (average_o),
    .average_valid_o (average_valid_o),
    .average_stall_i (average_stall_i)
  );

endmodule

// ===== rtl/maf_checker.sv =====
module maf_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        sample_valid_i,
  input logic                        sample_stall_o,
  input logic [maf_pkg::SampleW-1:0] average_o,
  input logic                        average_valid_o,
  input logic                        average_stall_i
);

  // a stalled result stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    average_valid_o && average_stall_i |=> average_valid_o && $stable(average_o))
    else $error("stalled average dropped or changed");

  // the front holds off the next sample while it updates the window
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sample_valid_i && !sample_stall_o |=> sample_stall_o)
    else $error("front accepted back-to-back samples");

  // no result can be offered straight out of reset
  assert property (@(posedge clk_i)
    !rst_ni |=> !average_valid_o)
    else $error("average valid right after reset");

  // the front stall falls only after it has been raised
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sample_stall_o) |-> $past(sample_stall_o))
    else $error("front stall dropped without being raised");

endmodule

bind moving_average_filter_top maf_checker u_maf_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .sample_valid_i  (sample_valid_i),
  .sample_stall_o  (sample_stall_o),
  .average_o       (average_o),
  .average_valid_o (average_valid_o),
  .average_stall_i (average_stall_i)
);
